// ===== hdl/pmsc_pkg.sv =====
package pmsc_pkg;

  // sequencer states: idle, five product steps on the one shared multiply, a last accumulate, finish
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_M1,
    ST_M2,
    ST_M3,
    ST_M4,
    ST_M5,
    ST_M6,
    ST_FIN
  } state_t;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_IDX_W-1:0] CFG_KP        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KI        = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KD        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ILIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_STIME     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SRATE     = 3'd5;

  // register reset values
  localparam logic [15:0] KP_RST     = 16'd256;
  localparam logic [15:0] KI_RST     = 16'd0;
  localparam logic [15:0] KD_RST     = 16'd0;
  localparam logic [30:0] ILIMIT_RST = 31'd268435456;
  localparam logic [15:0] STIME_RST  = 16'd1311;
  localparam logic [13:0] SRATE_RST  = 14'd50;

  // |target| at or below this is the pwm deadband (0.1 in Q4.12)
  localparam logic signed [15:0] DEADBAND = 16'sd409;

  // shared multiplier: signed 33 x signed 17
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 17;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int ACC_W   = PROD_W + 1;

endpackage

// ===== hdl/pmsc_if.sv =====
interface pmsc_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] target_velocity;
  logic signed [15:0] measured_velocity;

  modport source (output valid, output target_velocity, output measured_velocity,
                  input ready);
  modport sink   (input valid, input target_velocity, input measured_velocity,
                  output ready);
endinterface

interface pmsc_out_if;
  logic               valid;
  logic               ready;
  logic        [7:0]  pwm_duty;
  logic               forward;
  logic signed [15:0] control_output;

  modport source (output valid, output pwm_duty, output forward, output control_output,
                  input ready);
  modport sink   (input valid, input pwm_duty, input forward, input control_output,
                  output ready);
endinterface

// ===== hdl/pid_motor_speed_controller_unit.sv =====
// channel   | dir | payload                                         | handshake
// ----------+-----+-------------------------------------------------+------------
// in_ch     | in  | target_velocity, measured_velocity (Q4.12)      | valid/ready
// out_ch    | out | pwm_duty, forward, control_output (Q4.12)       | valid/ready
// cfg       | in  | cfg_we, cfg_index, cfg_wdata                    | write enable
//
// an item goes through accept, five products on the one shared 33x17 multiplier,
// a last accumulate, and a finish step that saturates, scales and loads the result
// in_ch.ready is high only while the sequencer sits idle
// the result sits in an output register, so the next item is taken while it waits;
// the finish step holds while an earlier result is still not taken
// synchronous active-low reset loads the default configuration and clears control and pid state
module pid_motor_speed_controller_unit (
  input  logic                           clk,
  input  logic                           rst_n,
  pmsc_in_if.sink                        in_ch,
  pmsc_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [pmsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pmsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import pmsc_pkg::*;

  // sequencer
  state_t state_r, state_nxt;

  // configuration registers
  logic [15:0] kp_r, ki_r, kd_r, stime_r;
  logic [30:0] ilimit_r;
  logic [13:0] srate_r;

  // pid state
  logic signed [16:0] prev_r;      // error of the last item, Q4.12
  logic signed [31:0] isum_r;      // clamped integral, Q4.28

  // per-item working registers
  logic signed [15:0]      t_r;
  logic signed [16:0]      e_r;
  logic signed [33:0]      iraw_r;   // integral before the clamp
  logic signed [31:0]      deriv_r;  // (e - prev) * rate, Q.12
  logic signed [PROD_W-1:0] prod_r;
  logic signed [ACC_W-1:0]  acc_r;   // pid sum, Q.20

  // output register
  logic               out_valid_r;
  logic [7:0]         pwm_r;
  logic               fwd_r;
  logic signed [15:0] ctl_r;

  // control
  logic accept;
  logic fin_go;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  assign accept = in_ch.valid && in_ch.ready;

  // ---------------------------------------------------------------------------
  // next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_M3;
      ST_M3:   state_nxt = ST_M4;
      ST_M4:   state_nxt = ST_M5;
      ST_M5:   state_nxt = ST_M6;
      ST_M6:   state_nxt = ST_FIN;
      ST_FIN:  if (fin_go) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // sequencer outputs: ready, finish enable and multiplier operand select
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ch.ready = 1'b0;
    fin_go      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;
    unique case (state_r)
      ST_IDLE: in_ch.ready = 1'b1;
      // e * sample_time, integral increment
      ST_M1: begin
        mul_a = MUL_A_W'(e_r);
        mul_b = {1'b0, stime_r};
      end
      // (e - prev) * sample_rate, derivative
      ST_M2: begin
        mul_a = MUL_A_W'(18'(e_r) - 18'(prev_r));
        mul_b = MUL_B_W'({3'b000, srate_r});
      end
      // kp * e
      ST_M3: begin
        mul_a = MUL_A_W'(e_r);
        mul_b = {1'b0, kp_r};
      end
      // ki * clamped integral
      ST_M4: begin
        mul_a = MUL_A_W'(isum_r);
        mul_b = {1'b0, ki_r};
      end
      // kd * derivative
      ST_M5: begin
        mul_a = MUL_A_W'(deriv_r);
        mul_b = {1'b0, kd_r};
      end
      ST_M6: ;
      ST_FIN: fin_go = !out_valid_r || out_ch.ready;
      default: ;
    endcase
  end

  // the one shared multiplier, registered into prod_r
  assign mul_p = mul_a * mul_b;

  // ---------------------------------------------------------------------------
  // integral clamp
  // ---------------------------------------------------------------------------
  logic signed [33:0] lim_pos, lim_neg;
  logic signed [31:0] iclamp;

  assign lim_pos = $signed({3'b000, ilimit_r});
  assign lim_neg = -lim_pos;

  always_comb begin
    priority if (iraw_r > lim_pos) begin
      iclamp = lim_pos[31:0];
    end else if (iraw_r < lim_neg) begin
      iclamp = lim_neg[31:0];
    end else begin
      iclamp = iraw_r[31:0];
    end
  end

  // ---------------------------------------------------------------------------
  // finish: floor to Q4.12, saturate, direction, duty scale and deadband
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [15:0]      o_sat, o_dir;
  logic                    fwd_c;
  logic [22:0]             scaled;
  logic [10:0]             duty_q;
  logic [7:0]              pwm_c;

  assign acc_sh = acc_r >>> 8;

  always_comb begin
    priority if (acc_sh > ACC_W'(32767)) begin
      o_sat = 16'sh7fff;
    end else if (acc_sh < -ACC_W'(32768)) begin
      o_sat = 16'sh8000;
    end else begin
      o_sat = acc_sh[15:0];
    end
  end

  always_comb begin
    fwd_c = t_r > 16'sd0;
    priority if (fwd_c) begin
      o_dir = o_sat;
    end else if (o_sat == 16'sh8000) begin
      o_dir = 16'sh7fff;   // negating the most negative value saturates
    end else begin
      o_dir = -o_sat;
    end
  end

  // o * 255 / 4096 as (o << 8) - o, then a shift
  assign scaled = {o_dir[14:0], 8'h00} - {8'h00, o_dir[14:0]};
  assign duty_q = scaled[22:12];

  always_comb begin
    priority if (o_dir <= 16'sd0) begin
      pwm_c = 8'd0;
    end else if (t_r <= DEADBAND && t_r >= -DEADBAND) begin
      pwm_c = 8'd0;
    end else if (duty_q > 11'd255) begin
      pwm_c = 8'd255;
    end else begin
      pwm_c = duty_q[7:0];
    end
  end

  // ---------------------------------------------------------------------------
  // control and state registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      kp_r        <= KP_RST;
      ki_r        <= KI_RST;
      kd_r        <= KD_RST;
      ilimit_r    <= ILIMIT_RST;
      stime_r     <= STIME_RST;
      srate_r     <= SRATE_RST;
      prev_r      <= '0;
      isum_r      <= '0;
    end else begin
      state_r <= state_nxt;

      if (fin_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        unique case (cfg_index)
          CFG_KP:     kp_r     <= cfg_wdata[15:0];
          CFG_KI:     ki_r     <= cfg_wdata[15:0];
          CFG_KD:     kd_r     <= cfg_wdata[15:0];
          CFG_ILIMIT: ilimit_r <= cfg_wdata;
          CFG_STIME:  stime_r  <= cfg_wdata[15:0];
          CFG_SRATE:  srate_r  <= cfg_wdata[13:0];
          default: ;  // writes past the register list are dropped
        endcase
      end

      // pid state moves once the derivative has used the old error
      if (state_r == ST_M3) begin
        prev_r <= e_r;
        isum_r <= iclamp;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          t_r <= in_ch.target_velocity;
          e_r <= 17'(in_ch.target_velocity) - 17'(in_ch.measured_velocity);
        end
      end
      ST_M1: ;
      ST_M2: iraw_r <= 34'(isum_r) + 34'($signed(prod_r[32:0]));
      ST_M3: deriv_r <= prod_r[31:0];
      ST_M4: acc_r <= ACC_W'(prod_r);                  // kp * e
      ST_M5: acc_r <= acc_r + ACC_W'(prod_r >>> 16);   // ki term floored to Q.20
      ST_M6: acc_r <= acc_r + ACC_W'(prod_r);          // kd * derivative
      ST_FIN: begin
        if (fin_go) begin
          pwm_r <= pwm_c;
          fwd_r <= fwd_c;
          ctl_r <= o_dir;
        end
      end
      default: ;
    endcase
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.pwm_duty       = pwm_r;
  assign out_ch.forward        = fwd_r;
  assign out_ch.control_output = ctl_r;

`ifndef SYNTHESIS
  // a new result only comes out of the finish step
  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FIN)
    else $error("result raised outside the finish step");

  // an accepted item starts the multiply sequence
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == ST_M1)
    else $error("accepted item did not start the sequence");

  // the finish step waits while the previous result is not taken
  a_fin_holds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN && out_valid_r && !out_ch.ready |=> state_r == ST_FIN)
    else $error("finish step overwrote a waiting result");

  // a nonzero duty only comes with a positive output
  a_pwm_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && pwm_r != 8'd0 |-> ctl_r > 16'sd0)
    else $error("nonzero duty with a non-positive output");
`endif

endmodule

// ===== sim/pid_motor_speed_controller_unit_tb.sv =====
`timescale 1ns / 100ps

module pid_motor_speed_controller_unit_tb;
  import pmsc_pkg::*;

  // receiver hold-off length, in cycles, for the back-pressure stretch
  localparam int HOLD_CYCLES  = 150;
  // settling time after the last result
  localparam int SETTLE_CYCLES = 16;

  // one result item as the block should produce it
  typedef struct packed {
    logic [7:0]         pwm_duty;
    logic               forward;
    logic signed [15:0] control_output;
  } drive_t;

  // tracks gains and pid state, predicts each result and checks it in order
  class pid_drive_scoreboard;
    int unsigned kp, ki, kd, int_limit, samp_time, samp_rate;
    int          prev_err;
    int          integ_acc;
    drive_t      expected_drive[$];
    int          errors;
    int          checked;

    function new();
      kp         = KP_RST;
      ki         = KI_RST;
      kd         = KD_RST;
      int_limit  = ILIMIT_RST;
      samp_time  = STIME_RST;
      samp_rate  = SRATE_RST;
      prev_err   = 0;
      integ_acc  = 0;
      errors     = 0;
      checked    = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_KP:     kp        = data[15:0];
        CFG_KI:     ki        = data[15:0];
        CFG_KD:     kd        = data[15:0];
        CFG_ILIMIT: int_limit = data[30:0];
        CFG_STIME:  samp_time = data[15:0];
        CFG_SRATE:  samp_rate = data[13:0];
        default: ;
      endcase
    endfunction

    function longint sat_q412(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
    endfunction

    function drive_t compute_drive(logic signed [15:0] tgt, logic signed [15:0] meas);
      longint t, m, e, deriv, integ, lim, acc, o, duty;
      drive_t r;
      t     = tgt;
      m     = meas;
      e     = t - m;
      deriv = (e - longint'(prev_err)) * longint'(samp_rate);
      lim   = longint'(int_limit);
      integ = longint'(integ_acc) + e * longint'(samp_time);
      if (integ > lim) integ = lim;
      if (integ < -lim) integ = -lim;
      prev_err   = int'(e);
      integ_acc  = int'(integ);
      // q.20 sum, integral product floored from q.36
      acc = longint'(kp) * e + ((longint'(ki) * integ) >>> 16) + longint'(kd) * deriv;
      o   = sat_q412(acc >>> 8);
      if (t > 0) begin
        r.forward = 1'b1;
      end else begin
        r.forward = 1'b0;
        o = sat_q412(-o);
      end
      if (o <= 0) begin
        duty = 0;
      end else begin
        duty = (o * 255) >>> 12;
        if (duty > 255) duty = 255;
      end
      if (t <= longint'(DEADBAND) && t >= -longint'(DEADBAND)) duty = 0;
      r.pwm_duty       = duty[7:0];
      r.control_output = o[15:0];
      return r;
    endfunction

    function void note_sample(logic signed [15:0] tgt, logic signed [15:0] meas);
      expected_drive.push_back(compute_drive(tgt, meas));
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("mismatch: %s", what);
    endtask

    task check_result(logic [7:0] pwm, logic fwd, logic signed [15:0] ctrl);
      drive_t want;
      checked++;
      if (expected_drive.size() == 0) begin
        report($sformatf("result pwm=%0d fwd=%0d ctrl=%0d with nothing expected",
                         pwm, fwd, ctrl));
      end else begin
        want = expected_drive.pop_front();
        if (pwm !== want.pwm_duty)
          report($sformatf("result %0d pwm_duty %0d, expected %0d",
                           checked, pwm, want.pwm_duty));
        if (fwd !== want.forward)
          report($sformatf("result %0d forward %0d, expected %0d",
                           checked, fwd, want.forward));
        if (ctrl !== want.control_output)
          report($sformatf("result %0d control_output %0d, expected %0d",
                           checked, ctrl, want.control_output));
      end
    endtask
  endclass

  // clock, reset and config port
  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  pmsc_in_if  in_ch ();
  pmsc_out_if out_ch ();

  pid_drive_scoreboard drive_book;

  // idle rates in percent, set per phase by the main sequence
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;

  // long receiver hold-off, armed once by the main sequence
  bit stall_armed = 1'b0;
  bit stall_done  = 1'b0;
  int stall_left  = 0;

  int samples_sent   = 0;
  int settings_used  = 0;
  int input_blocked  = 0;

  pid_motor_speed_controller_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // 2 ns period
  always #1 clk = ~clk;

  // receiver: random back-pressure, plus one long hold-off once armed
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      out_ch.ready <= 1'b0;
    end else if (stall_armed && !stall_done) begin
      // this cycle counts as the first of the hold-off
      stall_left = HOLD_CYCLES - 1;
      stall_done = 1'b1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
    end
  end

  // monitor: note each accepted sample, check each accepted result
  // inputs are noted first so an expectation is always queued before its result
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        drive_book.note_sample(in_ch.target_velocity, in_ch.measured_velocity);
      if (in_ch.valid && !in_ch.ready)
        input_blocked++;
      if (out_ch.valid && out_ch.ready)
        drive_book.check_result(out_ch.pwm_duty, out_ch.forward, out_ch.control_output);
    end
  end

  // offer one sample, idling first at the current sender rate
  // valid stays high after acceptance so back-to-back items need no toggle
  task automatic send_sample(input logic signed [15:0] tgt, input logic signed [15:0] meas);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid             <= 1'b1;
    in_ch.target_velocity   <= tgt;
    in_ch.measured_velocity <= meas;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    samples_sent++;
  endtask

  // stop offering and wait until every sent sample has its result
  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    while (drive_book.checked < samples_sent) @(posedge clk);
  endtask

  // one register write; the enable is dropped by the caller after the last one
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    drive_book.set_reg(idx, data);
    @(posedge clk);
  endtask

  // write all six registers while the block is idle
  task automatic write_settings(input int unsigned kp_v,
                                input int unsigned ki_v,
                                input int unsigned kd_v,
                                input int unsigned lim_v,
                                input int unsigned st_v,
                                input int unsigned sr_v);
    write_reg(CFG_KP, CFG_DATA_W'(kp_v));
    write_reg(CFG_KI, CFG_DATA_W'(ki_v));
    write_reg(CFG_KD, CFG_DATA_W'(kd_v));
    write_reg(CFG_ILIMIT, CFG_DATA_W'(lim_v));
    write_reg(CFG_STIME, CFG_DATA_W'(st_v));
    write_reg(CFG_SRATE, CFG_DATA_W'(sr_v));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // full-scale and near-zero velocities
  function automatic logic signed [15:0] corner_value();
    case ($urandom_range(4, 0))
      0:       return 16'sh8000;
      1:       return 16'sh7FFF;
      2:       return 16'sd0;
      3:       return 16'sd1;
      default: return -16'sd1;
    endcase
  endfunction

  // random samples: noise, tracking-like pairs, deadband-edge targets, corners and uniform pairs
  task automatic run_phase(input int count);
    logic signed [15:0] tgt, meas;
    int                 i;
    for (i = 0; i < count; i++) begin
      case ($urandom_range(5, 0))
        0: begin
          // full-range noise, every bit can toggle
          tgt  = 16'($urandom);
          meas = 16'($urandom);
        end
        1: begin
          // measured close to target, small error
          tgt  = 16'(int'($urandom_range(8192, 0)) - 4096);
          meas = tgt + 16'(int'($urandom_range(800, 0)) - 400);
        end
        2: begin
          // target around the deadband edge, both signs
          tgt = 16'($urandom_range(420, 400));
          if ($urandom_range(1, 0)) tgt = -tgt;
          meas = 16'(int'($urandom_range(4096, 0)) - 2048);
        end
        3: begin
          tgt  = corner_value();
          meas = corner_value();
        end
        default: begin
          tgt  = 16'(int'($urandom_range(16384, 0)) - 8192);
          meas = 16'(int'($urandom_range(16384, 0)) - 8192);
        end
      endcase
      send_sample(tgt, meas);
    end
  endtask

  // run limit, far beyond the slowest legal run
  initial begin
    #2_000_000;
    $display("timeout after %0d samples, %0d results", samples_sent, drive_book.checked);
    $display("pid_motor_speed_controller_unit_tb: FAIL");
    $finish;
  end

  // main sequence
  initial begin
    int ph;
    drive_book = new();
    rst_n                   = 1'b0;
    cfg_we                  = 1'b0;
    cfg_index               = '0;
    cfg_wdata               = '0;
    in_ch.valid             = 1'b0;
    in_ch.target_velocity   = '0;
    in_ch.measured_velocity = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part runs with the first idle mix
    send_idle_pct = 31;
    recv_idle_pct = 84;

    // reset gains: unit proportional only
    send_sample(16'sd0, 16'sd0);
    send_sample(16'sh7FFF, 16'sh8000);          // largest positive error
    send_sample(16'sh8000, 16'sh7FFF);          // largest negative error
    send_sample(16'sd409, 16'sd0);              // deadband edge, inside
    send_sample(16'sd410, 16'sd0);              // just outside deadband
    send_sample(-16'sd409, 16'sd0);
    send_sample(-16'sd410, 16'sd0);
    send_sample(-16'sd4096, 16'sh7FFF);         // negating full negative output saturates
    send_sample(16'sd4096, 16'sd0);             // output of exactly one, full duty
    send_sample(16'sd2048, 16'sd0);             // half duty
    send_sample(16'sd1000, 16'sd900);
    send_sample(16'sd0, -16'sd1000);            // zero target drives backward
    send_sample(16'sh5555, 16'shAAAA);
    wait_drain();

    // zero period freezes the integral, zero rate kills the derivative
    write_settings(0, 'hFFFF, 'hFFFF, 1000, 0, 0);
    send_sample(16'sd1000, 16'sd0);
    send_sample(16'sd2000, 16'sd500);
    send_sample(-16'sd3000, 16'sd0);
    wait_drain();

    // all terms active, widest limit, longest period, a high rate
    write_settings(256, 256, 1, 'h7FFF_FFFF, 'hFFFF, 10000);
    send_sample(16'sd4096, -16'sd4096);
    send_sample(-16'sd4096, 16'sd4096);
    send_sample(16'sd500, 16'sd500);
    send_sample(16'sh7FFF, 16'sh7FFF);
    send_sample(16'sd600, 16'sd0);
    wait_drain();

    // limit dropped to zero clamps the stored integral on the next step
    write_settings(256, 256, 1, 0, 'hFFFF, 10000);
    send_sample(16'sd1000, 16'sd0);
    send_sample(-16'sd1000, 16'sd0);
    wait_drain();

    // random phases: three idle mixes, several register settings
    for (ph = 0; ph < 8; ph++) begin
      if (ph < 3) begin
        send_idle_pct = 31;
        recv_idle_pct = 84;
      end else if (ph < 6) begin
        send_idle_pct = 84;
        recv_idle_pct = 31;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      // sender keeps offering while the receiver holds off, input must stall
      if (ph == 6) stall_armed = 1'b1;

      case (ph)
        0: write_settings(32'(KP_RST), 32'(KI_RST), 32'(KD_RST), 32'(ILIMIT_RST),
                          32'(STIME_RST), 32'(SRATE_RST));
        1: write_settings('hFFFF, 'hFFFF, 'hFFFF, 'h7FFF_FFFF, 'hFFFF, 10000);
        2: write_settings(0, 0, 0, 0, 1, 1);
        default: write_settings($urandom_range(2048, 0), $urandom_range(65535, 0),
                                $urandom_range(64, 0), $urandom_range('h7FFF_FFFF, 0),
                                $urandom_range(65535, 1), $urandom_range(10000, 1));
      endcase
      run_phase(85);
      wait_drain();
    end

    // let any stray result show up
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (drive_book.expected_drive.size() != 0)
      drive_book.report($sformatf("%0d expected results never arrived",
                                  drive_book.expected_drive.size()));

    $display("covered %0d samples under %0d register settings, %0d results checked",
             samples_sent, settings_used, drive_book.checked);
    $display("input held back %0d cycles, including a %0d-cycle output hold-off",
             input_blocked, HOLD_CYCLES);
    if (drive_book.errors == 0) begin
      $display("pid_motor_speed_controller_unit_tb: PASS");
    end else begin
      $display("pid_motor_speed_controller_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
